[src/aov_pkg.sv]
// aov_pkg: shared types and constants for the additive organ voice.
// Holds request codes, register indexes, envelope stages, controller
// states and the command/status structs. Depends on nothing.
package aov_pkg;

    // Field widths of the channels
    localparam int REQ_W      = 3;
    localparam int HIDX_W     = 5;
    localparam int AMP_W      = 16;
    localparam int PH_W       = 32;
    localparam int SMP_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Register widths
    localparam int HCOUNT_W = 6;
    localparam int GAIN_W   = 16;
    localparam int STEP_W   = 24;
    localparam int ENV_W    = 24;

    // Fixed-point layout
    localparam int FRAC_W      = 21;
    localparam int COARSE_W    = PH_W - FRAC_W;
    localparam int SUM_SHIFT   = 14;
    localparam int ENV_SHIFT   = 23;
    localparam int GAIN_SHIFT  = 15;
    localparam logic [ENV_W-1:0]  ENV_ONE    = 24'h800000;
    localparam logic [STEP_W-1:0] STEP_RESET = 24'd17476;
    localparam longint unsigned   PI_Q30     = 64'd3373259426;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_TICK         = 3'd0,
        REQ_LOAD         = 3'd1,
        REQ_NOTE_ON      = 3'd2,
        REQ_RELEASE      = 3'd3,
        REQ_FAST_RELEASE = 3'd4,
        REQ_RETRIGGER    = 3'd5
    } req_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HCOUNT       = 3'd0,
        CFG_GAIN         = 3'd1,
        CFG_ATTACK       = 3'd2,
        CFG_RELEASE      = 3'd3,
        CFG_FAST_RELEASE = 3'd4
    } cfg_index_t;

    // Envelope stages
    typedef enum logic [1:0] {
        ENV_ATTACK  = 2'd0,
        ENV_SUSTAIN = 2'd1,
        ENV_RELEASE = 2'd2
    } env_stage_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_SCALE,
        ST_GAIN,
        ST_EMIT
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic take;   // input word accepted this cycle
        logic issue;  // read next harmonic slot
        logic scale;  // sum times envelope
        logic gain;   // times voice gain
        logic emit;   // load the result register
    } aov_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic sounding;
        logic walk_done;
        logic pipe_busy;
        logic out_free;
    } aov_stat_t;

endpackage

[src/aov_ifs.sv]
// aov_ifs: valid/ready channel interfaces of the additive organ voice.
// Request channel, result channel and configuration write channel.
// Depends on aov_pkg for the field widths.
interface aov_req_if;
    import aov_pkg::*;

    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [HIDX_W-1:0]   harmonic_index;
    logic [AMP_W-1:0]    amplitude;
    logic [PH_W-1:0]     phase_increment;
    logic [PH_W-1:0]     start_phase;

    modport source (output valid, req_type, harmonic_index, amplitude,
                    phase_increment, start_phase, input ready);
    modport sink   (input valid, req_type, harmonic_index, amplitude,
                    phase_increment, start_phase, output ready);
endinterface

interface aov_res_if;
    import aov_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] sample;
    logic                    voice_active;

    modport source (output valid, sample, voice_active, input ready);
    modport sink   (input valid, sample, voice_active, output ready);
endinterface

interface aov_cfg_if;
    import aov_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[src/additive_organ_voice.sv]
// One additive organ voice: up to MAX_HARMONICS sine partials from a
// TABLE_SIZE-entry ROM with linear interpolation, summed and shaped by a
// linear attack/sustain/release envelope and an output gain. Load, note on,
// release, fast release and retrigger words give no result. A tick gives
// one result word: the harmonic walk issues one slot per cycle through a
// five-stage interpolation pipe, followed by two output multiplies; a tick
// on a silent voice skips the walk and the multiplies and gives a zero word.
// A finished tick also waits, before the next word is taken, while the
// previous result word stays unread in the result register.
// The result register lets the next word in while a result waits.
// Depends on aov_pkg, aov_ifs, aov_ctrl and aov_dp.
module additive_organ_voice #(
    parameter int TABLE_SIZE    = 2048,
    parameter int MAX_HARMONICS = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    aov_req_if.sink   voice_req,
    aov_res_if.source voice_res,
    aov_cfg_if.sink   cfg
);
    import aov_pkg::*;

    aov_cmd_t  cmd;
    aov_stat_t stat;

    // Register writes are always taken
    assign cfg.ready = 1'b1;

    // Sequencer
    aov_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (voice_req.valid),
        .req_type   (voice_req.req_type),
        .item_ready (voice_req.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // Datapath
    aov_dp #(
        .TABLE_SIZE    (TABLE_SIZE),
        .MAX_HARMONICS (MAX_HARMONICS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .req_type        (voice_req.req_type),
        .harmonic_index  (voice_req.harmonic_index),
        .amplitude       (voice_req.amplitude),
        .phase_increment (voice_req.phase_increment),
        .start_phase     (voice_req.start_phase),
        .cfg_we          (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .out_valid       (voice_res.valid),
        .out_ready       (voice_res.ready),
        .sample          (voice_res.sample),
        .voice_active    (voice_res.voice_active)
    );

    // A result is only loaded into a free result register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result loaded over a waiting word");

    // No word is taken while the harmonic pipe still holds work
    assert property (@(posedge clk) disable iff (!rst_n)
        (voice_req.valid && voice_req.ready) |-> !stat.pipe_busy)
        else $error("word accepted with harmonic pipe busy");

    // The envelope multiply only sees a finished sum
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scale |-> (!stat.pipe_busy && stat.walk_done))
        else $error("scale started before the walk drained");

    // A loaded result shows on the channel next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> voice_res.valid)
        else $error("emitted word not presented");

endmodule

[src/aov_ctrl.sv]
// aov_ctrl: sequencer of the voice. Accepts request words, walks the
// harmonic slots, then steps the two output multiplies and the result load.
// Depends on aov_pkg.
module aov_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    input  logic [aov_pkg::REQ_W-1:0]  req_type,
    output logic                       item_ready,
    input  aov_pkg::aov_stat_t         stat,
    output aov_pkg::aov_cmd_t          cmd
);
    import aov_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        item_ready = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                cmd.take   = item_valid;
                if (item_valid && (req_t'(req_type) == REQ_TICK))
                begin
                    // a silent voice skips the walk and answers with a zero word
                    state_next = stat.sounding ? ST_WALK : ST_EMIT;
                end
            end
            ST_WALK:
            begin
                cmd.issue = !stat.walk_done;
                if (stat.walk_done)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                cmd.gain   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[src/aov_dp.sv]
// aov_dp: datapath of the voice. Harmonic slot memories, sine ROM,
// five-stage interpolate/scale/accumulate pipe, envelope, output scaling
// and the result register. Depends on aov_pkg; driven by aov_ctrl.
module aov_dp #(
    parameter int TABLE_SIZE    = 2048,
    parameter int MAX_HARMONICS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  aov_pkg::aov_cmd_t                    cmd,
    output aov_pkg::aov_stat_t                   stat,
    // request payload
    input  logic [aov_pkg::REQ_W-1:0]            req_type,
    input  logic [aov_pkg::HIDX_W-1:0]           harmonic_index,
    input  logic [aov_pkg::AMP_W-1:0]            amplitude,
    input  logic [aov_pkg::PH_W-1:0]             phase_increment,
    input  logic [aov_pkg::PH_W-1:0]             start_phase,
    // configuration writes
    input  logic                                 cfg_we,
    input  logic [aov_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [aov_pkg::CFG_DATA_W-1:0]       cfg_data,
    // result register
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [aov_pkg::SMP_W-1:0]     sample,
    output logic                                 voice_active
);
    import aov_pkg::*;

    localparam int SLOT_W    = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
    localparam int CNT_W     = $clog2(MAX_HARMONICS + 1);
    localparam int IDX_W     = $clog2(TABLE_SIZE);
    localparam int MOD_W     = ($clog2(TABLE_SIZE + 1) > COARSE_W) ?
                               $clog2(TABLE_SIZE + 1) : COARSE_W;
    localparam int MOD_STEPS = ((2 ** COARSE_W) - 1) / TABLE_SIZE;
    localparam int ACC_PH_W  = PH_W + 3;
    localparam logic [ACC_PH_W-1:0] PH_LIMIT = ACC_PH_W'(TABLE_SIZE) << FRAC_W;
    localparam int DIFF_W    = SMP_W + 1;
    localparam int PRODC_W   = DIFF_W + FRAC_W + 1;
    localparam int VAL_W     = PRODC_W - FRAC_W;
    localparam int TERM_W    = VAL_W + AMP_W + 1;
    localparam int SUM_W     = TERM_W + CNT_W;
    localparam int S14_W     = SUM_W - SUM_SHIFT;
    localparam int P1_W      = S14_W + ENV_W + 1;
    localparam int S23_W     = P1_W - ENV_SHIFT;
    localparam int P2_W      = S23_W + GAIN_W + 1;
    localparam int S15_W     = P2_W - GAIN_SHIFT;
    localparam logic signed [S15_W-1:0] SAT_HI = S15_W'((2 ** (SMP_W - 1)) - 1);
    localparam logic signed [S15_W-1:0] SAT_LO = S15_W'(-(2 ** (SMP_W - 1)));

    typedef logic signed [SMP_W-1:0] rom_t [TABLE_SIZE];

    // Sine table, Q30 Taylor series folded to the first quadrant
    function automatic rom_t build_rom();
        rom_t            r;
        longint unsigned n;
        longint unsigned m;
        longint unsigned x;
        longint unsigned term;
        longint          acc;
        longint          v;
        logic            neg;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            n   = longint'(i);
            neg = 1'b0;
            if (2 * n > TABLE_SIZE)
            begin
                n   = TABLE_SIZE - n;
                neg = 1'b1;
            end
            m = 2 * n;
            if (2 * m > TABLE_SIZE)
            begin
                m = TABLE_SIZE - m;
            end
            x    = PI_Q30 * m / TABLE_SIZE;
            term = x;
            acc  = longint'(x);
            for (int k = 1; k <= 9; k++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                case (k)
                    1:       term = term / 6;
                    2:       term = term / 20;
                    3:       term = term / 42;
                    4:       term = term / 72;
                    5:       term = term / 110;
                    6:       term = term / 156;
                    7:       term = term / 210;
                    8:       term = term / 272;
                    default: term = term / 342;
                endcase
                if (k % 2 == 1)
                begin
                    acc = acc - longint'(term);
                end
                else
                begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0)
            begin
                acc = 0;
            end
            v = (acc + 64) >>> 7;
            if (v > 8388607)
            begin
                v = 8388607;
            end
            r[i] = neg ? SMP_W'(-v) : SMP_W'(v);
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // Configuration registers
    logic [HCOUNT_W-1:0] hcount_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [STEP_W-1:0]   attack_reg;
    logic [STEP_W-1:0]   release_reg;
    logic [STEP_W-1:0]   fast_reg;

    // Envelope and voice state
    logic [ENV_W-1:0]  env_level_reg, env_level_next;
    env_stage_t        env_stage_reg, env_stage_next;
    logic              sounding_reg, sounding_next;
    logic [STEP_W-1:0] cur_rel_reg, cur_rel_next;
    logic              mute_reg, mute_next;
    logic [ENV_W:0]    attack_sum;

    // Slot memories
    logic [PH_W-1:0]  ph_mem  [MAX_HARMONICS];
    logic [AMP_W-1:0] amp_mem [MAX_HARMONICS];
    logic [PH_W-1:0]  inc_mem [MAX_HARMONICS];

    // Walk counter
    logic [CNT_W-1:0] h_reg;
    logic [CNT_W-1:0] walk_len;

    // Pipe stage B: slot read
    logic              b_valid_reg;
    logic [SLOT_W-1:0] b_addr_reg;
    logic [PH_W-1:0]   ph_b_reg;
    logic [PH_W-1:0]   inc_b_reg;
    logic [AMP_W-1:0]  amp_b_reg;
    logic [MOD_W-1:0]  coarse_b;
    logic [IDX_W-1:0]  idx_b;
    logic [IDX_W-1:0]  nxt_b;
    logic [ACC_PH_W-1:0] ph_sum_b;
    logic [PH_W-1:0]   ph_new_b;

    // Pipe stage C: table entries
    logic                    c_valid_reg;
    logic signed [SMP_W-1:0] s0_c_reg;
    logic signed [SMP_W-1:0] s1_c_reg;
    logic [FRAC_W-1:0]       frac_c_reg;
    logic [AMP_W-1:0]        amp_c_reg;
    logic signed [DIFF_W-1:0]  diff_c;
    logic signed [PRODC_W-1:0] prod_c;

    // Pipe stage D: slope product
    logic                      d_valid_reg;
    logic signed [PRODC_W-1:0] prod_d_reg;
    logic signed [SMP_W-1:0]   s0_d_reg;
    logic [AMP_W-1:0]          amp_d_reg;
    logic signed [VAL_W-1:0]   val_d;
    logic signed [TERM_W-1:0]  term_d;

    // Pipe stage E: term
    logic                     e_valid_reg;
    logic signed [TERM_W-1:0] term_e_reg;

    // Sum and output scaling
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [S14_W-1:0] s14;
    logic signed [P1_W-1:0]  prod1_reg;
    logic signed [S23_W-1:0] s23;
    logic signed [P2_W-1:0]  prod2_reg;
    logic signed [S15_W-1:0] s15;
    logic signed [SMP_W-1:0] sat;

    // Result register
    logic                    out_valid_reg;
    logic signed [SMP_W-1:0] sample_reg;
    logic                    active_reg;

    logic take_tick;
    logic load_we;
    logic [SLOT_W-1:0] load_addr;

    assign take_tick = cmd.take && (req_t'(req_type) == REQ_TICK);
    assign load_we   = cmd.take && (req_t'(req_type) == REQ_LOAD) &&
                       (int'(harmonic_index) < MAX_HARMONICS);
    assign load_addr = SLOT_W'(harmonic_index);

    // Configuration writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hcount_reg  <= '0;
            gain_reg    <= '0;
            attack_reg  <= STEP_RESET;
            release_reg <= STEP_RESET;
            fast_reg    <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_HCOUNT:       hcount_reg  <= cfg_data[HCOUNT_W-1:0];
                CFG_GAIN:         gain_reg    <= cfg_data[GAIN_W-1:0];
                CFG_ATTACK:       attack_reg  <= cfg_data[STEP_W-1:0];
                CFG_RELEASE:      release_reg <= cfg_data[STEP_W-1:0];
                CFG_FAST_RELEASE: fast_reg    <= cfg_data[STEP_W-1:0];
                default:          ;
            endcase
        end
    end

    // Events and envelope step
    always_comb
    begin
        env_level_next = env_level_reg;
        env_stage_next = env_stage_reg;
        sounding_next  = sounding_reg;
        cur_rel_next   = cur_rel_reg;
        mute_next      = mute_reg;
        attack_sum     = {1'b0, env_level_reg} + {1'b0, attack_reg};
        if (cmd.take)
        begin
            case (req_t'(req_type))
                REQ_TICK:
                begin
                    if (!sounding_reg)
                    begin
                        mute_next = 1'b1;
                    end
                    else
                    begin
                        mute_next = 1'b0;
                        case (env_stage_reg)
                            ENV_ATTACK:
                            begin
                                if (attack_sum >= {1'b0, ENV_ONE})
                                begin
                                    env_level_next = ENV_ONE;
                                    env_stage_next = ENV_SUSTAIN;
                                end
                                else
                                begin
                                    env_level_next = attack_sum[ENV_W-1:0];
                                end
                            end
                            ENV_RELEASE:
                            begin
                                // ramp ends: silent from this tick on
                                if (env_level_reg <= cur_rel_reg)
                                begin
                                    env_level_next = '0;
                                    sounding_next  = 1'b0;
                                    mute_next      = 1'b1;
                                end
                                else
                                begin
                                    env_level_next = env_level_reg - cur_rel_reg;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                REQ_NOTE_ON:
                begin
                    env_level_next = '0;
                    env_stage_next = ENV_ATTACK;
                    sounding_next  = 1'b1;
                    cur_rel_next   = release_reg;
                end
                REQ_RELEASE:
                begin
                    if (sounding_reg)
                    begin
                        env_stage_next = ENV_RELEASE;
                    end
                end
                REQ_FAST_RELEASE:
                begin
                    if (sounding_reg)
                    begin
                        env_stage_next = ENV_RELEASE;
                        cur_rel_next   = fast_reg;
                    end
                end
                REQ_RETRIGGER:
                begin
                    env_stage_next = ENV_ATTACK;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            env_level_reg <= '0;
            env_stage_reg <= ENV_ATTACK;
            sounding_reg  <= 1'b0;
            cur_rel_reg   <= '0;
            mute_reg      <= 1'b1;
        end
        else
        begin
            env_level_reg <= env_level_next;
            env_stage_reg <= env_stage_next;
            sounding_reg  <= sounding_next;
            cur_rel_reg   <= cur_rel_next;
            mute_reg      <= mute_next;
        end
    end

    // Walk counter over the loaded slots
    assign walk_len = (int'(hcount_reg) > MAX_HARMONICS) ? CNT_W'(MAX_HARMONICS)
                                                          : CNT_W'(hcount_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg <= '0;
        end
        else if (take_tick)
        begin
            h_reg <= '0;
        end
        else if (cmd.issue)
        begin
            h_reg <= h_reg + 1'b1;
        end
    end

    // Slot memories: one write port (load or phase write-back), one read
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            amp_mem[load_addr] <= amplitude;
            inc_mem[load_addr] <= phase_increment;
            ph_mem[load_addr]  <= start_phase;
        end
        else if (b_valid_reg)
        begin
            ph_mem[b_addr_reg] <= ph_new_b;
        end
        if (cmd.issue)
        begin
            ph_b_reg  <= ph_mem[h_reg[SLOT_W-1:0]];
            inc_b_reg <= inc_mem[h_reg[SLOT_W-1:0]];
            amp_b_reg <= amp_mem[h_reg[SLOT_W-1:0]];
        end
    end

    // Stage B: table index, neighbour and phase advance
    always_comb
    begin
        coarse_b = MOD_W'(ph_b_reg[PH_W-1:FRAC_W]);
        for (int j = 0; j < MOD_STEPS; j++)
        begin
            if (coarse_b >= MOD_W'(TABLE_SIZE))
            begin
                coarse_b = coarse_b - MOD_W'(TABLE_SIZE);
            end
        end
        idx_b = coarse_b[IDX_W-1:0];
        nxt_b = (idx_b == IDX_W'(TABLE_SIZE - 1)) ? '0 : idx_b + 1'b1;

        ph_sum_b = ACC_PH_W'(ph_b_reg) + ACC_PH_W'(inc_b_reg);
        if (ph_sum_b >= PH_LIMIT)
        begin
            ph_sum_b = ph_sum_b - PH_LIMIT;
        end
        ph_new_b = ph_sum_b[PH_W-1:0];
    end

    // Stage C: slope times fraction
    assign diff_c = s1_c_reg - s0_c_reg;
    assign prod_c = diff_c * $signed({1'b0, frac_c_reg});

    // Stage D: interpolated value times amplitude
    assign val_d  = s0_d_reg + $signed(prod_d_reg[PRODC_W-1:FRAC_W]);
    assign term_d = val_d * $signed({1'b0, amp_d_reg});

    // Pipe valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= cmd.issue;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    // Pipe payload
    always_ff @(posedge clk)
    begin
        b_addr_reg <= h_reg[SLOT_W-1:0];
        s0_c_reg   <= SINE_ROM[idx_b];
        s1_c_reg   <= SINE_ROM[nxt_b];
        frac_c_reg <= ph_b_reg[FRAC_W-1:0];
        amp_c_reg  <= amp_b_reg;
        prod_d_reg <= prod_c;
        s0_d_reg   <= s0_c_reg;
        amp_d_reg  <= amp_c_reg;
        term_e_reg <= term_d;
    end

    // Accumulator and output multiplies
    assign s14 = $signed(sum_reg[SUM_W-1:SUM_SHIFT]);
    assign s23 = $signed(prod1_reg[P1_W-1:ENV_SHIFT]);
    assign s15 = $signed(prod2_reg[P2_W-1:GAIN_SHIFT]);

    always_ff @(posedge clk)
    begin
        if (take_tick)
        begin
            sum_reg <= '0;
        end
        else if (e_valid_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(term_e_reg);
        end
        if (cmd.scale)
        begin
            prod1_reg <= s14 * $signed({1'b0, env_level_reg});
        end
        if (cmd.gain)
        begin
            prod2_reg <= s23 * $signed({1'b0, gain_reg});
        end
    end

    // Saturate to the sample range
    always_comb
    begin
        if (s15 > SAT_HI)
        begin
            sat = SAT_HI[SMP_W-1:0];
        end
        else if (s15 < SAT_LO)
        begin
            sat = SAT_LO[SMP_W-1:0];
        end
        else
        begin
            sat = s15[SMP_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            sample_reg <= mute_reg ? '0 : sat;
            active_reg <= !mute_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample       = sample_reg;
    assign voice_active = active_reg;

    // Status to the controller
    assign stat.sounding  = sounding_reg;
    assign stat.walk_done = (h_reg == walk_len);
    assign stat.pipe_busy = b_valid_reg | c_valid_reg | d_valid_reg | e_valid_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

endmodule
